FILE: src/pidc_pkg.sv
package pidc_pkg;

  localparam int ElW = 20;
  localparam int AccW = 34;

  // Register indexes on the configuration port
  localparam logic [2:0] RegProp  = 3'd0;
  localparam logic [2:0] RegInteg = 3'd1;
  localparam logic [2:0] RegDeriv = 3'd2;
  localparam logic [2:0] RegLimit = 3'd3;
  localparam logic [2:0] RegMode  = 3'd4;

  // Loop modes
  localparam logic [1:0] ModeStd  = 2'd0;
  localparam logic [1:0] ModeDom  = 2'd1;
  localparam logic [1:0] ModeIpd  = 2'd2;
  localparam logic [1:0] ModeHold = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_IMUL,
    ST_IDIV,
    ST_DMUL,
    ST_DDIV,
    ST_PMUL,
    ST_GIMUL,
    ST_DGMUL,
    ST_SUM,
    ST_OUT
  } pidc_state_t;

endpackage

FILE: src/pidc_if.sv
interface pidc_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic signed [15:0] measured;
  logic signed [15:0] setpoint;
  logic [19:0] elapsed_us;
  modport source (output valid, operation, measured, setpoint, elapsed_us, input ready);
  modport sink (input valid, operation, measured, setpoint, elapsed_us, output ready);
endinterface

interface pidc_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] drive;
  modport source (output valid, drive, input ready);
  modport sink (input valid, drive, output ready);
endinterface

FILE: src/pid_controller_three_mode_top.sv
// Channel  | Dir | Words
// in_      | in  | operation, measured, setpoint, elapsed_us
// out_     | out | drive
// cfg_     | in  | APB-style, registers at 4*i
//
// Every product and quotient of a compute step goes through one shift-add
// multiplier and one restoring divider, one bit a cycle; the derivative division
// is skipped with zero elapsed time. Clear and hold skip the serial units.
// Synchronous active-low reset clears the configuration, loop state and control; a stalled output
// holds the word and blocks new input until the cycle after it is taken.
module pid_controller_three_mode_top
  import pidc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  pidc_in_if.sink     in_ch,
  pidc_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic signed [15:0] kp_r, ki_r, kd_r;
  logic [31:0] lim_r;
  logic [1:0]  mode_r;

  logic signed [AccW-1:0] integ_r;
  logic signed [16:0] perr_r;
  logic signed [15:0] pmeas_r;
  logic signed [31:0] last_r;

  pidc_state_t st_r, st_nxt;

  // Serial datapath registers
  logic [5:0]  cnt_r;
  logic signed [16:0] err_r;
  logic signed [15:0] meas_r;
  logic [ElW-1:0] dt_r;
  logic [63:0] prod_r;       // magnitude product, shift-add
  logic [63:0] mcand_r;      // shifted multiplicand
  logic [63:0] mplier_r;     // multiplier, shifted right
  logic        neg_r;
  logic [63:0] rem_r;
  logic [63:0] quo_r;
  logic signed [AccW-1:0] acc_r;
  logic signed [33:0] deriv_r;
  logic signed [63:0] sum_r;
  logic signed [31:0] drive_r;
  logic        ovalid_r;

  wire cfg_wr = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;

  // Configuration write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r <= '0; ki_r <= '0; kd_r <= '0; lim_r <= '0; mode_r <= ModeStd;
    end else if (cfg_wr) begin
      case (cfg_paddr[4:2])
        RegProp:  kp_r <= cfg_pwdata[15:0];
        RegInteg: ki_r <= cfg_pwdata[15:0];
        RegDeriv: kd_r <= cfg_pwdata[15:0];
        RegLimit: lim_r <= cfg_pwdata;
        RegMode:  mode_r <= cfg_pwdata[1:0];
        default: ;
      endcase
    end
  end

  // Register read
  always_comb begin
    case (cfg_paddr[4:2])
      RegProp:  cfg_prdata = {{16{kp_r[15]}}, kp_r};
      RegInteg: cfg_prdata = {{16{ki_r[15]}}, ki_r};
      RegDeriv: cfg_prdata = {{16{kd_r[15]}}, kd_r};
      RegLimit: cfg_prdata = lim_r;
      RegMode:  cfg_prdata = {30'd0, mode_r};
      default:  cfg_prdata = '0;
    endcase
  end

  assign in_ch.ready  = (st_r == ST_IDLE) && !ovalid_r;
  assign out_ch.valid = ovalid_r;
  assign out_ch.drive = drive_r;

  wire in_acc = in_ch.valid & in_ch.ready;

  // Helpers for signed magnitude
  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    mag64 = v[63] ? 64'(-v) : 64'(v);
  endfunction

  // Trial subtraction of the restoring divider
  logic [63:0] rem_sh;
  logic [63:0] dvs;
  logic [64:0] trial;
  always_comb begin
    rem_sh = {rem_r[62:0], quo_r[63]};
    dvs = (st_r == ST_IDIV) ? 64'd2000000 : {44'd0, dt_r};
    trial = {1'b0, rem_sh} - {1'b0, dvs};
  end

  // Signed quotient of the serial divider
  logic signed [63:0] qres;
  assign qres = neg_r ? -$signed(quo_r) : $signed(quo_r);

  logic signed [63:0] acc_sum;
  logic signed [63:0] lim_s;
  assign acc_sum = $signed(64'(integ_r)) + qres;
  assign lim_s = $signed({32'd0, lim_r});

  logic signed [17:0] ddelta;
  assign ddelta = (mode_r == ModeStd) ? 18'(err_r) - 18'(perr_r)
                                      : 18'(meas_r) - 18'(pmeas_r);

  // Next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:  if (in_acc) begin
        if (in_ch.operation || mode_r == ModeHold) st_nxt = ST_OUT;
        else st_nxt = ST_IMUL;
      end
      ST_IMUL:  if (cnt_r == 6'd37) st_nxt = ST_IDIV;
      ST_IDIV:  if (cnt_r == 6'd63) st_nxt = ST_DMUL;
      ST_DMUL:  if (cnt_r == 6'd20) st_nxt = (dt_r == '0) ? ST_PMUL : ST_DDIV;
      ST_DDIV:  if (cnt_r == 6'd63) st_nxt = ST_PMUL;
      ST_PMUL:  if (cnt_r == 6'd16) st_nxt = ST_GIMUL;
      ST_GIMUL: if (cnt_r == 6'd16) st_nxt = ST_DGMUL;
      ST_DGMUL: if (cnt_r == 6'd16) st_nxt = ST_SUM;
      ST_SUM:   st_nxt = ST_OUT;
      ST_OUT:   if (!ovalid_r || out_ch.ready) st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_IDLE;
    else st_r <= st_nxt;
  end

  // Datapath: load each serial unit as its phase begins, step one bit a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0; perr_r <= '0; pmeas_r <= '0; last_r <= '0;
      ovalid_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (ovalid_r && out_ch.ready) ovalid_r <= 1'b0;
      if (st_nxt != st_r) cnt_r <= '0;
      else cnt_r <= cnt_r + 6'd1;
      case (st_r)
        ST_IDLE: if (in_acc) begin
          meas_r <= in_ch.measured;
          err_r <= 17'(in_ch.setpoint) - 17'(in_ch.measured);
          dt_r <= in_ch.elapsed_us;
          if (in_ch.operation) begin
            integ_r <= '0; perr_r <= '0; pmeas_r <= '0; last_r <= '0;
            drive_r <= '0;
          end else if (mode_r == ModeHold) begin
            drive_r <= last_r;
          end else begin
            // (e + prev_e) * dt * 65536: multiplier walks dt and the 16 shift
            mcand_r <= mag64(64'(18'(17'(in_ch.setpoint) - 17'(in_ch.measured))
                       + 18'(perr_r)));
            neg_r <= (18'(17'(in_ch.setpoint) - 17'(in_ch.measured))
                     + 18'(perr_r)) < 0 ? 1'b0 : 1'b0;
            mplier_r <= {28'd0, in_ch.elapsed_us, 16'd0};
            prod_r <= '0;
            sum_r <= $signed(64'(signed'(18'(17'(in_ch.setpoint)
                     - 17'(in_ch.measured)) + 18'(perr_r))));
          end
        end
        ST_IMUL: begin
          if (cnt_r == 6'd0) neg_r <= sum_r[63];
          if (mplier_r[0]) prod_r <= prod_r + mcand_r;
          mcand_r <= {mcand_r[62:0], 1'b0};
          mplier_r <= {1'b0, mplier_r[63:1]};
          if (cnt_r == 6'd37) begin
            quo_r <= mplier_r[0] ? prod_r + mcand_r : prod_r;
            rem_r <= '0;
          end
        end
        ST_IDIV, ST_DDIV: begin
          if (trial[64]) rem_r <= rem_sh;
          else rem_r <= trial[63:0];
          quo_r <= {quo_r[62:0], ~trial[64]};
        end
        default: ;
      endcase

      // Integral update and clamp once the increment is known
      if (st_r == ST_DMUL && cnt_r == 6'd0) begin
        if (acc_sum > lim_s) acc_r <= AccW'(lim_s);
        else if (acc_sum < -lim_s) acc_r <= AccW'(-lim_s);
        else acc_r <= AccW'(acc_sum);
        // delta * 1e6, 20 bits of the constant walked from here
        mcand_r <= mag64(64'(ddelta));
        neg_r <= ddelta[17];
        mplier_r <= 64'd1000000;
        prod_r <= '0;
      end else if (st_r == ST_DMUL) begin
        if (mplier_r[0]) prod_r <= prod_r + mcand_r;
        mcand_r <= {mcand_r[62:0], 1'b0};
        mplier_r <= {1'b0, mplier_r[63:1]};
      end
      if (st_r == ST_DMUL && cnt_r == 6'd20) begin
        quo_r <= mplier_r[0] ? prod_r + mcand_r : prod_r;
        rem_r <= '0;
        if (dt_r == '0) deriv_r <= '0;
      end

      // Saturate the derivative, then load the proportional product
      if (st_r == ST_PMUL && cnt_r == 6'd0) begin
        if (dt_r != '0) begin
          if (qres > 64'sd2147483647) deriv_r <= 34'sd2147483647;
          else if (qres < -64'sd2147483648) deriv_r <= -34'sd2147483648;
          else deriv_r <= 34'(qres);
        end
        mcand_r <= mag64(64'((mode_r == ModeIpd) ? -18'(meas_r) : 18'(err_r)));
        mplier_r <= mag64(64'(kp_r));
        neg_r <= ((mode_r == ModeIpd) ? (meas_r > 0) : err_r[16]) ^ kp_r[15];
        prod_r <= '0;
      end

      // Shared 16-bit gain multiply: shift-add steps after the load
      if ((st_r == ST_PMUL || st_r == ST_GIMUL || st_r == ST_DGMUL)
          && cnt_r != 6'd0) begin
        if (mplier_r[0]) prod_r <= prod_r + mcand_r;
        mcand_r <= {mcand_r[62:0], 1'b0};
        mplier_r <= {1'b0, mplier_r[63:1]};
      end
      if (st_r == ST_PMUL && cnt_r == 6'd16) begin
        sum_r <= neg_r ? -$signed(mplier_r[0] ? prod_r + mcand_r : prod_r)
                       : $signed(mplier_r[0] ? prod_r + mcand_r : prod_r);
      end
      if (st_r == ST_GIMUL && cnt_r == 6'd0) begin
        mcand_r <= mag64(64'(acc_r));
        mplier_r <= mag64(64'(ki_r));
        neg_r <= acc_r[AccW-1] ^ ki_r[15];
        prod_r <= '0;
      end
      if (st_r == ST_GIMUL && cnt_r == 6'd16) begin
        // floor of the Q.16 product
        sum_r <= sum_r + ((neg_r ? -$signed(mplier_r[0] ? prod_r + mcand_r : prod_r)
                        : $signed(mplier_r[0] ? prod_r + mcand_r : prod_r)) >>> 16);
      end
      if (st_r == ST_DGMUL && cnt_r == 6'd0) begin
        mcand_r <= mag64(64'(deriv_r));
        mplier_r <= mag64(64'(kd_r));
        neg_r <= deriv_r[33] ^ kd_r[15] ^ (mode_r != ModeStd);
        prod_r <= '0;
      end
      if (st_r == ST_DGMUL && cnt_r == 6'd16) begin
        sum_r <= sum_r + (neg_r ? -$signed(mplier_r[0] ? prod_r + mcand_r : prod_r)
                        : $signed(mplier_r[0] ? prod_r + mcand_r : prod_r));
      end

      // Saturate and commit state
      if (st_r == ST_SUM) begin
        if (sum_r > 64'sd2147483647) drive_r <= 32'sh7fffffff;
        else if (sum_r < -64'sd2147483648) drive_r <= 32'sh80000000;
        else drive_r <= 32'(sum_r);
        last_r <= (sum_r > 64'sd2147483647) ? 32'sh7fffffff :
                  (sum_r < -64'sd2147483648) ? 32'sh80000000 : 32'(sum_r);
        integ_r <= acc_r;
        perr_r <= err_r;
        if (mode_r != ModeStd) pmeas_r <= meas_r;
      end

      // Present the word
      if (st_r == ST_OUT && (!ovalid_r || out_ch.ready)) ovalid_r <= 1'b1;
    end
  end

endmodule

FILE: src/pidc_checker.sv
module pidc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [31:0] out_drive
);
  // Drive holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_drive)) else $error("drive moved");
  // No new input while a word waits
  a_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready) else $error("input taken during stall");
  // An accepted item never yields an immediate word
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid || $past(out_valid)) else $error("early word");
endmodule

bind pid_controller_three_mode_top pidc_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_drive(out_ch.drive)
);

FILE: test/tb_pid_controller_three_mode_top.sv
module tb_pid_controller_three_mode_top
  import pidc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [4:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic cfg_pready;

  pidc_in_if in_ch();
  pidc_out_if out_ch();

  pid_controller_three_mode_top u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // Controller copy: registers and loop state
  longint kp, ki, kd, ilim;
  logic [1:0] mode;
  longint integ, perr, pmeas, ldrive;

  logic signed [31:0] drive_q[$];
  int mismatches, words_out, n_clear, n_hold;
  bit quiet_in, quiet_out;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Advance the controller copy by one word and return the drive
  function automatic longint pid_step(bit op, longint m, longint s, longint dt);
    longint e, acc, delta, dv, pt, sum, prod, q;
    if (op) begin
      integ = 0; perr = 0; pmeas = 0; ldrive = 0;
      return 0;
    end
    if (mode == ModeHold) return ldrive;
    e = s - m;
    acc = integ + ((e + perr) * dt * 65536) / 2000000;
    if (acc > ilim) acc = ilim;
    else if (acc < -ilim) acc = -ilim;
    delta = (mode == ModeStd) ? e - perr : m - pmeas;
    dv = (dt == 0) ? 0 : clip32((delta * 1000000) / dt);
    pt = (mode == ModeIpd) ? -m : e;
    prod = acc * ki;
    q = prod / 65536;
    if (prod % 65536 != 0 && prod < 0) q -= 1;
    sum = pt * kp + q;
    if (mode == ModeStd) sum += dv * kd;
    else sum -= dv * kd;
    sum = clip32(sum);
    integ = acc; perr = e;
    if (mode != ModeStd) pmeas = m;
    ldrive = sum;
    return sum;
  endfunction

  // Write one register: setup then access phase, then back to idle
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    case (idx)
      RegProp:  kp = longint'($signed(val[15:0]));
      RegInteg: ki = longint'($signed(val[15:0]));
      RegDeriv: kd = longint'($signed(val[15:0]));
      RegLimit: ilim = longint'(val);
      default:  mode = val[1:0];
    endcase
    @(negedge clk);
  endtask

  task automatic drain();
    while (drive_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_all(logic [15:0] p, logic [15:0] i, logic [15:0] d,
                         logic [31:0] lim, logic [1:0] md);
    drain();
    write_reg(RegProp, {16'd0, p});
    write_reg(RegInteg, {16'd0, i});
    write_reg(RegDeriv, {16'd0, d});
    write_reg(RegLimit, lim);
    write_reg(RegMode, {30'd0, md});
  endtask

  // Send one word, predicting its drive at acceptance
  task automatic send_word(bit op, logic [15:0] m, logic [15:0] s, logic [19:0] dt);
    while (!quiet_in && $urandom_range(99) < 14) @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.operation <= op; in_ch.measured <= m;
    in_ch.setpoint <= s; in_ch.elapsed_us <= dt;
    do @(posedge clk); while (!in_ch.ready);
    drive_q.push_back(32'(pid_step(op, longint'($signed(m)),
                                   longint'($signed(s)), longint'(dt))));
    if (op) n_clear++;
    else if (mode == ModeHold) n_hold++;
    @(negedge clk);
    in_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic rand_word(int clr_pct);
    logic [19:0] dt;
    case ($urandom_range(5))
      0: dt = 20'd0;
      1: dt = 20'hFFFFF;
      2: dt = 20'($urandom_range(1, 20));
      default: dt = 20'($urandom_range(100, 20000));
    endcase
    send_word($urandom_range(99) < clr_pct, 16'($urandom), 16'($urandom), dt);
  endtask

  // Check each drive word against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      words_out++;
      if (drive_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected drive word %0d", out_ch.drive);
      end else begin
        if (out_ch.drive !== drive_q[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("drive mismatch: expected %0d got %0d", drive_q[0], out_ch.drive);
        end
        void'(drive_q.pop_front());
      end
    end
  end

  // Receiver stalls
  always @(negedge clk) begin
    out_ch.ready <= quiet_out ? 1'b1 : ($urandom_range(99) >= 14);
  end

  task automatic test_edges();
    set_all(16'h0100, 16'h0080, 16'h0010, 32'h0010_0000, ModeStd);
    send_word(1'b0, 16'h8000, 16'h7FFF, 20'hFFFFF);
    send_word(1'b0, 16'h7FFF, 16'h8000, 20'd1);
    send_word(1'b0, 16'd5, 16'd10, 20'd0);
    send_word(1'b0, 16'h0000, 16'h0000, 20'd1000);
    send_word(1'b1, 16'h1234, 16'h4321, 20'd55);
    set_all(16'h7FFF, 16'h7FFF, 16'h7FFF, 32'hFFFF_FFFF, ModeDom);
    send_word(1'b0, 16'h8000, 16'h7FFF, 20'hFFFFF);
    send_word(1'b0, 16'h7FFF, 16'h8000, 20'd1);
    send_word(1'b0, 16'h0001, 16'hFFFF, 20'd3);
    set_all(16'h8000, 16'h8000, 16'h8000, 32'd0, ModeIpd);
    send_word(1'b0, 16'h8000, 16'h0000, 20'd1);
    send_word(1'b0, 16'h7FFF, 16'h1000, 20'd0);
    send_word(1'b0, 16'h0100, 16'hFF00, 20'd777);
    set_all(16'h8000, 16'h8000, 16'h8000, 32'd0, ModeHold);
    send_word(1'b0, 16'h0100, 16'h0200, 20'd10);
    send_word(1'b1, 16'h0100, 16'h0200, 20'd10);
    send_word(1'b0, 16'h0100, 16'h0200, 20'd10);
  endtask

  task automatic test_random_modes();
    for (int ph = 0; ph < 8; ph++) begin
      set_all(16'($urandom), 16'($urandom), 16'($urandom),
              ($urandom_range(1) != 0) ? $urandom : 32'($urandom_range(0, 32'h0004_0000)),
              2'(ph % 4));
      quiet_in = (ph == 5); quiet_out = (ph == 5);
      for (int k = 0; k < 120; k++) rand_word(4);
    end
    quiet_in = 1'b0; quiet_out = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0; in_ch.operation = 1'b0; in_ch.measured = '0;
    in_ch.setpoint = '0; in_ch.elapsed_us = '0; out_ch.ready = 1'b0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = '0; cfg_pwdata = '0;
    kp = 0; ki = 0; kd = 0; ilim = 0; mode = ModeStd;
    integ = 0; perr = 0; pmeas = 0; ldrive = 0;
    mismatches = 0; words_out = 0; n_clear = 0; n_hold = 0;
    quiet_in = 1'b0; quiet_out = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_edges();
    test_random_modes();
    drain();
    repeat (300) @(negedge clk);
    $display("Checked %0d drive words over all four loop modes (%0d clears, %0d holds).",
             words_out, n_clear, n_hold);
    if (mismatches == 0 && drive_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: ~1000 words plus stalls, taken several times over
  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: files.f
src/pidc_pkg.sv
src/pidc_if.sv
src/pid_controller_three_mode_top.sv
src/pidc_checker.sv
test/tb_pid_controller_three_mode_top.sv
